>>> sv/gcaa_pkg.sv
`timescale 1ns / 1ps
package gcaa_pkg;
   localparam int MAX_NODES_DEF  = 64;
   localparam int MAX_TRUCKS_DEF = 8;
   localparam int DIST_BITS_DEF  = 24;
   localparam int LOAD_W = 22;
   localparam int LEN_W  = 31;
   localparam int TAB_W  = 16;
   localparam int QDEPTH = 2;

   typedef enum logic [2:0] {
      REQ_DIST   = 3'd0,
      REQ_DEMAND = 3'd1,
      REQ_CAP    = 3'd2,
      REQ_ASSIGN = 3'd3,
      REQ_REPORT = 3'd4,
      REQ_CLEAR  = 3'd5,
      REQ_RSV6   = 3'd6,
      REQ_RSV7   = 3'd7
   } req_code_type;

   typedef enum logic [1:0] {
      ST_PLACED   = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_INVALID  = 2'd2,
      ST_REPORT   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CMD_ASSIGN  = 2'd0,
      CMD_REPORT  = 2'd1,
      CMD_CLEAR   = 2'd2,
      CMD_INVALID = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      BK_IDLE, BK_DEM, BK_SCAN, BK_RD0, BK_RD1, BK_RD2, BK_EVAL,
      BK_UPD0, BK_UPD1, BK_UPD2, BK_RLEN, BK_REP0, BK_REP1, BK_REP2, BK_INV, BK_MOD
   } back_state_type;
endpackage

>>> sv/greedy_cheapest_append_assign_top.sv
`timescale 1ns / 1ps
// Greedy cheapest-append truck assignment. Table writes go to the tables on acceptance.
// An assign scans the active trucks one at a time through the single distance-table
// read port: each fitting truck takes three distance reads and a cost compare, a
// non-fitting one is skipped, and when no truck fits a node-mod-trucks fallback picks
// one before the update. A report gives one result per active truck. Results appear
// for one cycle on rsp_valid and the receiver cannot stall them; busy is high while
// a transaction is queued or in the back end.
module greedy_cheapest_append_assign_top #(
   parameter int MAX_NODES  = gcaa_pkg::MAX_NODES_DEF,
   parameter int MAX_TRUCKS = gcaa_pkg::MAX_TRUCKS_DEF,
   parameter int DIST_BITS  = gcaa_pkg::DIST_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_type,
   input  logic [5:0]  req_row,
   input  logic [5:0]  req_col,
   input  logic [23:0] req_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_data,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_truck,
   output logic [21:0] rsp_load,
   output logic [30:0] rsp_route_length,
   output logic        rsp_last
);
   localparam int NB = $clog2(MAX_NODES);
   localparam int TB = (MAX_TRUCKS > 1) ? $clog2(MAX_TRUCKS) : 1;

   logic [3:0] trucks_ff;
   logic dist_we, dem_we, cap_we, q_valid, q_pop, back_idle;
   logic [2*NB-1:0] dist_waddr, dist_raddr;
   logic [DIST_BITS-1:0] dist_wdata, dist_rdata;
   logic [NB-1:0] dem_waddr, dem_raddr;
   logic [gcaa_pkg::TAB_W-1:0] dem_wdata, dem_rdata, cap_wdata, cap_rdata;
   logic [TB-1:0] cap_waddr, cap_raddr;
   gcaa_pkg::cmd_type q_cmd;
   logic [5:0] q_node;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         trucks_ff <= 4'd8;
      end else if (csr_valid) begin
         trucks_ff <= csr_data;
      end
   end

   gcaa_front #(.MAX_NODES(MAX_NODES), .MAX_TRUCKS(MAX_TRUCKS), .DIST_BITS(DIST_BITS)) u_front (
      .clock, .reset, .start, .busy, .req_type, .req_row, .req_col, .req_value,
      .dist_we, .dist_waddr, .dist_wdata, .dem_we, .dem_waddr, .dem_wdata,
      .cap_we, .cap_waddr, .cap_wdata, .q_valid, .q_cmd, .q_node, .q_pop, .back_idle
   );

   gcaa_ram #(.WIDTH(DIST_BITS), .DEPTH(MAX_NODES*MAX_NODES)) u_dist (
      .clock, .wr_en(dist_we), .wr_addr(dist_waddr), .wr_data(dist_wdata),
      .rd_addr(dist_raddr), .rd_data(dist_rdata)
   );
   gcaa_ram #(.WIDTH(gcaa_pkg::TAB_W), .DEPTH(MAX_NODES)) u_dem (
      .clock, .wr_en(dem_we), .wr_addr(dem_waddr), .wr_data(dem_wdata),
      .rd_addr(dem_raddr), .rd_data(dem_rdata)
   );
   gcaa_ram #(.WIDTH(gcaa_pkg::TAB_W), .DEPTH(1 << TB)) u_cap (
      .clock, .wr_en(cap_we), .wr_addr(cap_waddr), .wr_data(cap_wdata),
      .rd_addr(cap_raddr), .rd_data(cap_rdata)
   );

   gcaa_back #(.MAX_NODES(MAX_NODES), .MAX_TRUCKS(MAX_TRUCKS), .DIST_BITS(DIST_BITS)) u_back (
      .clock, .reset, .trucks_cfg(trucks_ff), .q_valid, .q_cmd, .q_node, .q_pop,
      .idle(back_idle), .dist_raddr, .dist_rdata, .dem_raddr, .dem_rdata,
      .cap_raddr, .cap_rdata, .rsp_valid, .rsp_status, .rsp_truck, .rsp_load,
      .rsp_route_length, .rsp_last
   );
endmodule

>>> sv/gcaa_ram.sv
`timescale 1ns / 1ps
module gcaa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;
endmodule

>>> sv/gcaa_front.sv
`timescale 1ns / 1ps
module gcaa_front #(
   parameter int MAX_NODES  = gcaa_pkg::MAX_NODES_DEF,
   parameter int MAX_TRUCKS = gcaa_pkg::MAX_TRUCKS_DEF,
   parameter int DIST_BITS  = gcaa_pkg::DIST_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [2:0]                    req_type,
   input  logic [5:0]                    req_row,
   input  logic [5:0]                    req_col,
   input  logic [23:0]                   req_value,
   output logic                          dist_we,
   output logic [2*$clog2(MAX_NODES)-1:0] dist_waddr,
   output logic [DIST_BITS-1:0]          dist_wdata,
   output logic                          dem_we,
   output logic [$clog2(MAX_NODES)-1:0]  dem_waddr,
   output logic [gcaa_pkg::TAB_W-1:0]    dem_wdata,
   output logic                          cap_we,
   output logic [$clog2(MAX_TRUCKS)-1:0] cap_waddr,
   output logic [gcaa_pkg::TAB_W-1:0]    cap_wdata,
   output logic                          q_valid,
   output gcaa_pkg::cmd_type             q_cmd,
   output logic [5:0]                    q_node,
   input  logic                          q_pop,
   input  logic                          back_idle
);
   localparam int NB = $clog2(MAX_NODES);
   localparam int TB = (MAX_TRUCKS > 1) ? $clog2(MAX_TRUCKS) : 1;
   localparam int QB = $clog2(gcaa_pkg::QDEPTH);

   gcaa_pkg::cmd_type qc_ff [gcaa_pkg::QDEPTH];
   logic [5:0] qn_ff [gcaa_pkg::QDEPTH];
   logic [QB-1:0] wp_ff, rp_ff;
   logic [QB:0] cnt_ff;
   logic acc, push;
   gcaa_pkg::cmd_type pcmd;
   logic [23:0] dmax;

   assign busy = (cnt_ff == (QB+1)'(gcaa_pkg::QDEPTH)) || !back_idle;
   assign acc = start && !busy;
   assign dmax = 24'((64'd1 << DIST_BITS) - 64'd1);

   always_comb begin
      push = 1'b0;
      pcmd = gcaa_pkg::CMD_ASSIGN;
      dist_we = 1'b0;
      dem_we = 1'b0;
      cap_we = 1'b0;
      unique case (gcaa_pkg::req_code_type'(req_type))
         gcaa_pkg::REQ_DIST: begin
            dist_we = acc && (32'(req_row) < MAX_NODES) && (32'(req_col) < MAX_NODES);
         end
         gcaa_pkg::REQ_DEMAND: begin
            dem_we = acc && (32'(req_row) < MAX_NODES);
         end
         gcaa_pkg::REQ_CAP: begin
            cap_we = acc && (32'(req_row) < MAX_TRUCKS);
         end
         gcaa_pkg::REQ_ASSIGN: begin
            push = acc;
            pcmd = (req_row == 6'd0 || 32'(req_row) >= MAX_NODES) ?
                   gcaa_pkg::CMD_INVALID : gcaa_pkg::CMD_ASSIGN;
         end
         gcaa_pkg::REQ_REPORT: begin
            push = acc;
            pcmd = gcaa_pkg::CMD_REPORT;
         end
         gcaa_pkg::REQ_CLEAR: begin
            push = acc;
            pcmd = gcaa_pkg::CMD_CLEAR;
         end
         default: ;
      endcase
   end

   assign dist_waddr = {req_row[NB-1:0], req_col[NB-1:0]};
   assign dist_wdata = DIST_BITS'((req_value > dmax) ? dmax : req_value);
   assign dem_waddr = req_row[NB-1:0];
   assign dem_wdata = (req_value > 24'hFFFF) ? 16'hFFFF : req_value[15:0];
   assign cap_waddr = TB'(req_row);
   assign cap_wdata = dem_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= wp_ff + 1'b1;
         end
         if (q_pop) begin
            rp_ff <= rp_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + (QB+1)'(push) - (QB+1)'(q_pop);
      end
      if (push) begin
         qc_ff[wp_ff] <= pcmd;
         qn_ff[wp_ff] <= req_row;
      end
   end

   assign q_valid = cnt_ff != '0;
   assign q_cmd = qc_ff[rp_ff];
   assign q_node = qn_ff[rp_ff];
endmodule

>>> sv/gcaa_back.sv
`timescale 1ns / 1ps
module gcaa_back #(
   parameter int MAX_NODES  = gcaa_pkg::MAX_NODES_DEF,
   parameter int MAX_TRUCKS = gcaa_pkg::MAX_TRUCKS_DEF,
   parameter int DIST_BITS  = gcaa_pkg::DIST_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [3:0]                     trucks_cfg,
   input  logic                           q_valid,
   input  gcaa_pkg::cmd_type              q_cmd,
   input  logic [5:0]                     q_node,
   output logic                           q_pop,
   output logic                           idle,
   output logic [2*$clog2(MAX_NODES)-1:0] dist_raddr,
   input  logic [DIST_BITS-1:0]           dist_rdata,
   output logic [$clog2(MAX_NODES)-1:0]   dem_raddr,
   input  logic [gcaa_pkg::TAB_W-1:0]     dem_rdata,
   output logic [$clog2(MAX_TRUCKS)-1:0]  cap_raddr,
   input  logic [gcaa_pkg::TAB_W-1:0]     cap_rdata,
   output logic                           rsp_valid,
   output logic [1:0]                     rsp_status,
   output logic [2:0]                     rsp_truck,
   output logic [21:0]                    rsp_load,
   output logic [30:0]                    rsp_route_length,
   output logic                           rsp_last
);
   localparam int NB = $clog2(MAX_NODES);
   localparam int TB = (MAX_TRUCKS > 1) ? $clog2(MAX_TRUCKS) : 1;
   localparam int KB = (NB > 1) ? $clog2(NB) : 1;
   localparam int MW = NB + TB + 1;
   localparam int LW = gcaa_pkg::LOAD_W;
   localparam int PW = gcaa_pkg::LEN_W;
   localparam int CW = DIST_BITS + 3;
   localparam logic [LW-1:0] LMAX = '1;
   localparam logic [PW-1:0] PMAX = '1;

   gcaa_pkg::back_state_type st_ff, st_in;
   logic [LW-1:0] load_ff [MAX_TRUCKS];
   logic [NB-1:0] lst_ff [MAX_TRUCKS];
   logic [MAX_TRUCKS-1:0] emp_ff;
   logic [PW-1:0] open_ff [MAX_TRUCKS];

   logic [NB-1:0] node_ff;
   logic [TB:0] t_ff, n_ff;
   logic [TB-1:0] best_ff;
   logic have_ff;
   logic signed [CW-1:0] bcost_ff;
   logic [gcaa_pkg::TAB_W-1:0] dem_ff;
   logic [DIST_BITS-1:0] d0_ff, d1_ff;
   logic status_ovf_ff;
   logic [PW:0] sum_ff;
   logic [NB-1:0] md_ff, md_nx;
   logic [KB-1:0] mk_ff;
   logic [MW-1:0] msh;

   logic [TB-1:0] ti;
   logic [3:0] ncfg;
   logic fits;
   logic signed [CW-1:0] cost;

   logic rv_ff, rl_ff;
   logic [1:0] rs_ff;
   logic [2:0] rt_ff;
   logic [21:0] rld_ff;
   logic [30:0] rlen_ff;

   assign ti = t_ff[TB-1:0];
   assign ncfg = (trucks_cfg == 4'd0) ? 4'd1 :
                 (32'(trucks_cfg) > MAX_TRUCKS) ? 4'(MAX_TRUCKS) : trucks_cfg;
   assign fits = ({1'b0, load_ff[ti]} + (LW+1)'(dem_ff)) <= (LW+1)'(cap_rdata);
   // capacity read runs one truck ahead of the scan
   assign cap_raddr = ((st_ff == gcaa_pkg::BK_EVAL) ||
                       ((st_ff == gcaa_pkg::BK_SCAN) && !fits)) ? ti + TB'(1) : ti;
   assign dem_raddr = (st_ff == gcaa_pkg::BK_IDLE) ? q_node[NB-1:0] : node_ff;
   assign idle = (st_ff == gcaa_pkg::BK_IDLE) && !q_valid;

   // round-robin fallback: node mod trucks, one restoring step per cycle
   assign msh = MW'(n_ff) << mk_ff;
   assign md_nx = (MW'(md_ff) >= msh) ? NB'(MW'(md_ff) - msh) : md_ff;

   // d0: from last to node (or depot to node), d1: node to depot, dist_rdata: last to depot
   assign cost = emp_ff[ti] ? CW'({d0_ff, 1'b0}) :
                 CW'(d0_ff) + CW'(d1_ff) - CW'(dist_rdata);

   always_comb begin
      st_in = st_ff;
      q_pop = 1'b0;
      dist_raddr = {lst_ff[ti], node_ff};
      unique case (st_ff)
         gcaa_pkg::BK_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               unique case (q_cmd)
                  gcaa_pkg::CMD_ASSIGN:  st_in = gcaa_pkg::BK_DEM;
                  gcaa_pkg::CMD_REPORT:  st_in = gcaa_pkg::BK_REP0;
                  gcaa_pkg::CMD_CLEAR:   st_in = gcaa_pkg::BK_IDLE;
                  gcaa_pkg::CMD_INVALID: st_in = gcaa_pkg::BK_INV;
                  default: st_in = gcaa_pkg::BK_IDLE;
               endcase
            end
         end
         gcaa_pkg::BK_DEM: st_in = gcaa_pkg::BK_SCAN;
         gcaa_pkg::BK_SCAN: begin
            st_in = (t_ff == n_ff) ? (have_ff ? gcaa_pkg::BK_UPD0 : gcaa_pkg::BK_MOD) :
                    fits ? gcaa_pkg::BK_RD0 : gcaa_pkg::BK_SCAN;
            dist_raddr = emp_ff[ti] ? {{NB{1'b0}}, node_ff} : {lst_ff[ti], node_ff};
         end
         gcaa_pkg::BK_RD0: begin
            st_in = gcaa_pkg::BK_RD1;
            dist_raddr = {node_ff, {NB{1'b0}}};
         end
         gcaa_pkg::BK_RD1: begin
            st_in = gcaa_pkg::BK_RD2;
            dist_raddr = {lst_ff[ti], {NB{1'b0}}};
         end
         gcaa_pkg::BK_RD2: begin
            st_in = gcaa_pkg::BK_EVAL;
            dist_raddr = {lst_ff[ti], {NB{1'b0}}};
         end
         gcaa_pkg::BK_EVAL: st_in = gcaa_pkg::BK_SCAN;
         gcaa_pkg::BK_MOD: st_in = (mk_ff == '0) ? gcaa_pkg::BK_UPD0 : gcaa_pkg::BK_MOD;
         gcaa_pkg::BK_UPD0: begin
            st_in = gcaa_pkg::BK_UPD1;
            dist_raddr = emp_ff[best_ff] ? {{NB{1'b0}}, node_ff} : {lst_ff[best_ff], node_ff};
         end
         gcaa_pkg::BK_UPD1: begin
            st_in = gcaa_pkg::BK_UPD2;
            dist_raddr = {node_ff, {NB{1'b0}}};
         end
         gcaa_pkg::BK_UPD2: st_in = gcaa_pkg::BK_RLEN;
         gcaa_pkg::BK_RLEN: st_in = gcaa_pkg::BK_IDLE;
         gcaa_pkg::BK_REP0: begin
            st_in = (t_ff == n_ff) ? gcaa_pkg::BK_IDLE : gcaa_pkg::BK_REP1;
            dist_raddr = {lst_ff[ti], {NB{1'b0}}};
         end
         gcaa_pkg::BK_REP1: begin
            st_in = gcaa_pkg::BK_REP2;
            dist_raddr = {lst_ff[ti], {NB{1'b0}}};
         end
         gcaa_pkg::BK_REP2: st_in = gcaa_pkg::BK_REP0;
         gcaa_pkg::BK_INV: st_in = gcaa_pkg::BK_IDLE;
         default: st_in = gcaa_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= gcaa_pkg::BK_IDLE;
         emp_ff <= '1;
         rv_ff <= 1'b0;
         for (int i = 0; i < MAX_TRUCKS; i++) begin
            load_ff[i] <= '0;
            lst_ff[i] <= '0;
            open_ff[i] <= '0;
         end
      end else begin
         st_ff <= st_in;
         rv_ff <= 1'b0;
         unique case (st_ff)
            gcaa_pkg::BK_IDLE: begin
               t_ff <= '0;
               n_ff <= (TB+1)'(ncfg);
               have_ff <= 1'b0;
               node_ff <= q_node[NB-1:0];
               if (q_valid && q_cmd == gcaa_pkg::CMD_CLEAR) begin
                  emp_ff <= '1;
                  for (int i = 0; i < MAX_TRUCKS; i++) begin
                     load_ff[i] <= '0;
                     lst_ff[i] <= '0;
                     open_ff[i] <= '0;
                  end
               end
            end
            gcaa_pkg::BK_DEM: dem_ff <= dem_rdata;
            gcaa_pkg::BK_SCAN: begin
               if (t_ff == n_ff) begin
                  status_ovf_ff <= !have_ff;
                  md_ff <= node_ff;
                  mk_ff <= KB'(NB - 1);
               end else if (!fits) begin
                  t_ff <= t_ff + 1'b1;
               end
            end
            gcaa_pkg::BK_MOD: begin
               md_ff <= md_nx;
               mk_ff <= mk_ff - 1'b1;
               if (mk_ff == '0) begin
                  best_ff <= TB'(md_nx);
               end
            end
            gcaa_pkg::BK_RD0: d0_ff <= dist_rdata;
            gcaa_pkg::BK_RD1: d1_ff <= dist_rdata;
            gcaa_pkg::BK_EVAL: begin
               if (!have_ff || cost < bcost_ff) begin
                  have_ff <= 1'b1;
                  best_ff <= ti;
                  bcost_ff <= cost;
               end
               t_ff <= t_ff + 1'b1;
            end
            gcaa_pkg::BK_UPD1: begin
               if (emp_ff[best_ff]) begin
                  open_ff[best_ff] <= ((PW+1)'(dist_rdata) > (PW+1)'(PMAX)) ? PMAX :
                                      PW'(dist_rdata);
               end else begin
                  open_ff[best_ff] <= (({1'b0, open_ff[best_ff]} + (PW+1)'(dist_rdata)) >
                                       (PW+1)'(PMAX)) ? PMAX :
                                      open_ff[best_ff] + PW'(dist_rdata);
               end
               load_ff[best_ff] <= (({1'b0, load_ff[best_ff]} + (LW+1)'(dem_ff)) >
                                    (LW+1)'(LMAX)) ? LMAX : load_ff[best_ff] + LW'(dem_ff);
               lst_ff[best_ff] <= node_ff;
               emp_ff[best_ff] <= 1'b0;
            end
            gcaa_pkg::BK_UPD2: sum_ff <= {1'b0, open_ff[best_ff]} + (PW+1)'(dist_rdata);
            gcaa_pkg::BK_RLEN: begin
               rv_ff <= 1'b1;
               rs_ff <= status_ovf_ff ? gcaa_pkg::ST_OVERFLOW : gcaa_pkg::ST_PLACED;
               rt_ff <= 3'(best_ff);
               rld_ff <= load_ff[best_ff];
               rlen_ff <= (sum_ff > (PW+1)'(PMAX)) ? PMAX : sum_ff[PW-1:0];
               rl_ff <= 1'b1;
            end
            gcaa_pkg::BK_REP1: sum_ff <= {1'b0, open_ff[ti]};
            gcaa_pkg::BK_REP2: begin
               rv_ff <= 1'b1;
               rs_ff <= gcaa_pkg::ST_REPORT;
               rt_ff <= 3'(ti);
               rld_ff <= load_ff[ti];
               rlen_ff <= emp_ff[ti] ? '0 :
                          ((sum_ff + (PW+1)'(dist_rdata)) > (PW+1)'(PMAX)) ? PMAX :
                          PW'(sum_ff + (PW+1)'(dist_rdata));
               rl_ff <= (t_ff + 1'b1) == n_ff;
               t_ff <= t_ff + 1'b1;
            end
            gcaa_pkg::BK_INV: begin
               rv_ff <= 1'b1;
               rs_ff <= gcaa_pkg::ST_INVALID;
               rt_ff <= '0;
               rld_ff <= '0;
               rlen_ff <= '0;
               rl_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_status = rs_ff;
   assign rsp_truck = rt_ff;
   assign rsp_load = rld_ff;
   assign rsp_route_length = rlen_ff;
   assign rsp_last = rl_ff;
endmodule
